// ===== design/ptpr_pkg.sv =====
// ptpr_pkg: shared types, constants and lookup functions for the tile renderer.
// Pattern table, palette table, job word and register-set types.
// No dependencies.
`timescale 1ns / 1ps

package ptpr_pkg;

    // tile geometry
    localparam int TILE_SIZE = 8;
    localparam int TILE_W    = 3;
    localparam logic [TILE_W-1:0] TILE_LAST = 3'(TILE_SIZE - 1);

    // field widths
    localparam int ADDR_W   = 15;
    localparam int COLOR_W  = 8;
    localparam int PAT_W    = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 4;
    localparam int PSEL_W   = 8;
    localparam int HIDDEN_W = 5;
    localparam int COLS_W   = 5;
    localparam int ENTRY_W  = 4;
    localparam int PITCH_W  = COLS_W + TILE_W;

    // parameter defaults
    localparam int DEF_MAX_COLUMNS      = 16;
    localparam int DEF_MAX_VISIBLE_ROWS = 32;

    // register set
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_PALETTE = 2'd0;
    localparam logic [1:0] REG_HIDDEN  = 2'd1;
    localparam logic [1:0] REG_COLUMNS = 2'd2;
    localparam logic [PSEL_W-1:0]   RST_PALETTE = 8'd0;
    localparam logic [HIDDEN_W-1:0] RST_HIDDEN  = 5'd0;
    localparam logic [COLS_W-1:0]   RST_COLUMNS = 5'd10;

    localparam logic [COLOR_W-1:0] ALPHA = 8'hBF;

    // pixel classes
    localparam logic [1:0] CLS_BLACK = 2'd0;
    localparam logic [1:0] CLS_PAL1  = 2'd1;
    localparam logic [1:0] CLS_PAL2  = 2'd2;
    localparam logic [1:0] CLS_WHITE = 2'd3;

    // queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PSEL_W-1:0]   palette_select;
        logic [HIDDEN_W-1:0] skip_rows;
        logic [COLS_W-1:0]   columns;
    } t_cfg;

    // one tile job handed from front to back
    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic [ENTRY_W-1:0] entry;
        logic [PITCH_W-1:0] pitch;
        logic [ADDR_W-1:0]  base;
    } t_job;

    // pattern rows indexed {pattern, y}; pixel x sits at bits [2*(7-x)+1 : 2*(7-x)]
    localparam logic [15:0] TILE_ROWS [0:31] = '{
        16'hD554, 16'h7FF4, 16'h7FF4, 16'h7FF4, 16'h7FF4, 16'h7FF4, 16'h5554, 16'h0000,
        16'hEAA8, 16'hBEA8, 16'hBAA8, 16'hAAA8, 16'hAAA8, 16'hAAA8, 16'hAAA8, 16'h0000,
        16'hD554, 16'h7D54, 16'h7554, 16'h5554, 16'h5554, 16'h5554, 16'h5554, 16'h0000,
        16'hAAAA, 16'hAAAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'h5555, 16'h0000
    };

    function automatic logic [1:0] tile_class(
        input logic [PAT_W-1:0]  pattern,
        input logic [TILE_W-1:0] y,
        input logic [TILE_W-1:0] x
    );
        logic [15:0] row_bits;
        row_bits = TILE_ROWS[{pattern, y}];
        return row_bits[{~x, 1'b1} -: 2];
    endfunction

    // {red, green, blue} for a pixel class and palette entry
    function automatic logic [3*COLOR_W-1:0] pixel_rgb(
        input logic [1:0]         cls,
        input logic [ENTRY_W-1:0] entry
    );
        logic [3*COLOR_W-1:0] c1;
        logic [3*COLOR_W-1:0] c2;
        logic [3*COLOR_W-1:0] rgb;
        case (entry)
            4'd0: begin c1 = 24'h0058F8; c2 = 24'h3CBCFC; end
            4'd1: begin c1 = 24'h00A800; c2 = 24'hB8F818; end
            4'd2: begin c1 = 24'hD800CC; c2 = 24'hF878F8; end
            4'd3: begin c1 = 24'h0058F8; c2 = 24'h58D854; end
            4'd4: begin c1 = 24'hE40058; c2 = 24'h58F898; end
            4'd5: begin c1 = 24'h58F898; c2 = 24'h6888FC; end
            4'd6: begin c1 = 24'hF83800; c2 = 24'h7C7C7C; end
            4'd7: begin c1 = 24'h6844FC; c2 = 24'hA80020; end
            4'd8: begin c1 = 24'h0058F8; c2 = 24'hF83800; end
            4'd9: begin c1 = 24'hF83800; c2 = 24'hFCA044; end
            default: begin c1 = '0; c2 = '0; end
        endcase
        case (cls)
            CLS_PAL1:  rgb = c1;
            CLS_PAL2:  rgb = c2;
            CLS_WHITE: rgb = 24'hFFFFFF;
            default:   rgb = '0;
        endcase
        return rgb;
    endfunction

endpackage

// ===== design/palette_tile_pixel_renderer.sv =====
// palette_tile_pixel_renderer: top level of the tile renderer.
// Instantiates ptpr_regs, ptpr_front, ptpr_queue and ptpr_back; uses ptpr_pkg.
//
// Usage:
//   Draw requests: drive i_tile_pattern, i_cell_row, i_cell_column with start;
//   a request is taken at a clock edge where start is high and busy is low.
//   Each visible request produces 64 pixel words, row-major, on
//   o_pixel_address / o_alpha / o_blue / o_green / o_red / o_last_pixel,
//   each valid for one cycle while o_valid is high; o_last_pixel marks the
//   64th word. Requests above the hidden rows or past the visible height are
//   taken and produce nothing.
//   The first word of a tile passes through the job queue, the walker's pixel
//   counters and the output word register before it reaches the outputs.
//   Throughput: one word per cycle while a tile is walked; the single pixel
//   walker sets that figure. Tiles follow each other with no gap when the
//   next job is already queued. A two-job queue sits between request decode
//   and the walker; busy is high while it is full.
//   The output has no back-pressure: every word must be taken when shown.
//   Registers (APB, 0x0 palette, 0x4 hidden rows, 0x8 columns) must be
//   written only while the block is idle; the block does not enforce this.
//   Reset (synchronous, i_rst_n low): queue and walker empty, o_valid low,
//   registers back to palette 0, hidden rows 0, columns 10.
`timescale 1ns / 1ps

module palette_tile_pixel_renderer #(
    parameter int MAX_COLUMNS      = ptpr_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_VISIBLE_ROWS = ptpr_pkg::DEF_MAX_VISIBLE_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ptpr_pkg::PAT_W-1:0]          i_tile_pattern,
    input  logic [ptpr_pkg::ROW_W-1:0]          i_cell_row,
    input  logic [ptpr_pkg::COL_W-1:0]          i_cell_column,
    output logic                                o_valid,
    output logic [ptpr_pkg::ADDR_W-1:0]         o_pixel_address,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_alpha,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_blue,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_green,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_red,
    output logic                                o_last_pixel,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptpr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptpr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptpr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    ptpr_pkg::t_cfg cfg;
    ptpr_pkg::t_job push_job;
    ptpr_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;

    // configuration registers
    ptpr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // request decode
    ptpr_front #(
        .MAX_COLUMNS      (MAX_COLUMNS),
        .MAX_VISIBLE_ROWS (MAX_VISIBLE_ROWS)
    ) u_front (
        .i_start        (start),
        .i_full         (q_full),
        .i_cfg          (cfg),
        .i_tile_pattern (i_tile_pattern),
        .i_cell_row     (i_cell_row),
        .i_cell_column  (i_cell_column),
        .o_busy         (busy),
        .o_push         (push),
        .o_job          (push_job)
    );

    // job queue
    ptpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (head_job)
    );

    // pixel walker
    ptpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (q_valid),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_pixel_address (o_pixel_address),
        .o_alpha         (o_alpha),
        .o_blue          (o_blue),
        .o_green         (o_green),
        .o_red           (o_red),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

// ===== design/ptpr_regs.sv =====
// ptpr_regs: APB-style register file (palette, hidden rows, columns).
// Depends on ptpr_pkg.
`timescale 1ns / 1ps

module ptpr_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptpr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptpr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptpr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ptpr_pkg::t_cfg                      o_cfg
);

    ptpr_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.palette_select <= ptpr_pkg::RST_PALETTE;
            r_cfg.skip_rows      <= ptpr_pkg::RST_HIDDEN;
            r_cfg.columns        <= ptpr_pkg::RST_COLUMNS;
        end else if (wr_en) begin
            case (reg_idx)
                ptpr_pkg::REG_PALETTE: r_cfg.palette_select <= pwdata[ptpr_pkg::PSEL_W-1:0];
                ptpr_pkg::REG_HIDDEN:  r_cfg.skip_rows      <= pwdata[ptpr_pkg::HIDDEN_W-1:0];
                ptpr_pkg::REG_COLUMNS: r_cfg.columns        <= pwdata[ptpr_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            ptpr_pkg::REG_PALETTE: prdata = 32'(r_cfg.palette_select);
            ptpr_pkg::REG_HIDDEN:  prdata = 32'(r_cfg.skip_rows);
            ptpr_pkg::REG_COLUMNS: prdata = 32'(r_cfg.columns);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/ptpr_front.sv =====
// ptpr_front: takes draw requests, drops off-screen cells, builds tile jobs.
// Depends on ptpr_pkg.
`timescale 1ns / 1ps

module ptpr_front #(
    parameter int MAX_COLUMNS      = ptpr_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_VISIBLE_ROWS = ptpr_pkg::DEF_MAX_VISIBLE_ROWS
) (
    input  logic                            i_start,
    input  logic                            i_full,
    input  ptpr_pkg::t_cfg                  i_cfg,
    input  logic [ptpr_pkg::PAT_W-1:0]      i_tile_pattern,
    input  logic [ptpr_pkg::ROW_W-1:0]      i_cell_row,
    input  logic [ptpr_pkg::COL_W-1:0]      i_cell_column,
    output logic                            o_busy,
    output logic                            o_push,
    output ptpr_pkg::t_job                  o_job
);

    logic [ptpr_pkg::ROW_W-1:0]    vis_row;
    logic                          on_screen;
    logic [ptpr_pkg::COLS_W-1:0]   cols;
    logic [ptpr_pkg::ROW_W+ptpr_pkg::COLS_W-1:0] row_cells;
    logic [ptpr_pkg::ROW_W+ptpr_pkg::COLS_W+5:0] base_full;
    logic [4:0]                    quot;
    logic [8:0]                    quot_x10;
    logic [15:0]                   recip;

    assign o_busy = i_full;

    // visibility: below the hidden band and inside the visible height
    always_comb begin
        vis_row   = i_cell_row - ptpr_pkg::ROW_W'(i_cfg.skip_rows);
        on_screen = (i_cell_row >= ptpr_pkg::ROW_W'(i_cfg.skip_rows))
                    && ({1'b0, vis_row} < 7'(MAX_VISIBLE_ROWS));
    end

    // clamp width, then base address of the tile's top-left pixel
    always_comb begin
        cols = (7'(i_cfg.columns) > 7'(MAX_COLUMNS)) ? ptpr_pkg::COLS_W'(MAX_COLUMNS)
                                                      : i_cfg.columns;
        row_cells = vis_row * cols;
        base_full = {row_cells, 6'b0}
                  + (ptpr_pkg::ROW_W + ptpr_pkg::COLS_W + 6)'({i_cell_column, 3'b0});
    end

    // palette entry = select mod 10, via reciprocal 205/2048 (exact below 1029)
    always_comb begin
        recip    = i_cfg.palette_select * 8'd205;
        quot     = recip[15:11];
        quot_x10 = {1'b0, quot, 3'b0} + {3'b0, quot, 1'b0};
    end

    always_comb begin
        o_job.pattern = i_tile_pattern;
        o_job.entry   = ptpr_pkg::ENTRY_W'(9'(i_cfg.palette_select) - quot_x10);
        o_job.pitch   = {cols, 3'b0};
        o_job.base    = base_full[ptpr_pkg::ADDR_W-1:0];
    end

    // off-screen requests are accepted and dropped
    assign o_push = i_start && !i_full && on_screen;

endmodule

// ===== design/ptpr_queue.sv =====
// ptpr_queue: short job queue between front and back.
// Depends on ptpr_pkg.
`timescale 1ns / 1ps

module ptpr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ptpr_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output ptpr_pkg::t_job  o_job
);

    localparam int PTR_W = $clog2(ptpr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ptpr_pkg::QUEUE_DEPTH + 1);

    ptpr_pkg::t_job   r_mem [ptpr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(ptpr_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(ptpr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(ptpr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/ptpr_back.sv =====
// ptpr_back: walks one tile job, one pixel word per cycle, registered outputs.
// Depends on ptpr_pkg.
`timescale 1ns / 1ps

module ptpr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  ptpr_pkg::t_job                      i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    output logic [ptpr_pkg::ADDR_W-1:0]         o_pixel_address,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_alpha,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_blue,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_green,
    output logic [ptpr_pkg::COLOR_W-1:0]        o_red,
    output logic                                o_last_pixel
);

    logic                               r_active;
    logic [ptpr_pkg::TILE_W-1:0]        r_x;
    logic [ptpr_pkg::TILE_W-1:0]        r_y;
    logic [ptpr_pkg::PAT_W-1:0]         r_pattern;
    logic [ptpr_pkg::ENTRY_W-1:0]       r_entry;
    logic [ptpr_pkg::PITCH_W-1:0]       r_pitch;
    logic [ptpr_pkg::ADDR_W-1:0]        r_row_addr;

    logic                               r_valid;
    logic [ptpr_pkg::ADDR_W-1:0]        r_pixel_address;
    logic [3*ptpr_pkg::COLOR_W-1:0]     r_rgb;
    logic                               r_last_pixel;

    logic                               end_x;
    logic                               end_tile;
    logic [1:0]                         cls;
    logic [3*ptpr_pkg::COLOR_W-1:0]     rgb;

    // current pixel
    always_comb begin
        end_x    = (r_x == ptpr_pkg::TILE_LAST);
        end_tile = end_x && (r_y == ptpr_pkg::TILE_LAST);
        cls      = ptpr_pkg::tile_class(r_pattern, r_y, r_x);
        rgb      = ptpr_pkg::pixel_rgb(cls, r_entry);
    end

    // take the next job when idle or on the tile's last word
    assign o_pop = i_job_valid && (!r_active || end_tile);

    // pixel walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_x      <= '0;
                r_y      <= '0;
            end else if (r_active) begin
                if (end_tile) begin
                    r_active <= 1'b0;
                end
                r_x <= r_x + 1'b1;
                if (end_x) begin
                    r_y <= r_y + 1'b1;
                end
            end
        end
    end

    // job fields and row address
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pattern  <= i_job.pattern;
            r_entry    <= i_job.entry;
            r_pitch    <= i_job.pitch;
            r_row_addr <= i_job.base;
        end else if (r_active && end_x) begin
            r_row_addr <= r_row_addr + ptpr_pkg::ADDR_W'(r_pitch);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_pixel_address <= r_row_addr + ptpr_pkg::ADDR_W'(r_x);
            r_rgb           <= rgb;
            r_last_pixel    <= end_tile;
        end
    end

    assign o_valid         = r_valid;
    assign o_pixel_address = r_pixel_address;
    assign o_alpha         = ptpr_pkg::ALPHA;
    assign o_red           = r_rgb[23:16];
    assign o_green         = r_rgb[15:8];
    assign o_blue          = r_rgb[7:0];
    assign o_last_pixel    = r_last_pixel;

endmodule

// ===== design/ptpr_checker.sv =====
// ptpr_checker: port-level assertions for the tile renderer, bound to the top.
// Depends on ptpr_pkg and palette_tile_pixel_renderer.
`timescale 1ns / 1ps

module ptpr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                busy,
    input  logic                                o_valid,
    input  logic [ptpr_pkg::COLOR_W-1:0]        o_alpha,
    input  logic [ptpr_pkg::COLOR_W-1:0]        o_blue,
    input  logic [ptpr_pkg::COLOR_W-1:0]        o_green,
    input  logic [ptpr_pkg::COLOR_W-1:0]        o_red,
    input  logic                                o_last_pixel
);

    // a tile's 64 words come out without a gap
    a_tile_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_pixel |=> o_valid)
        else $error("pixel word stream broke inside a tile");

    // bottom-right pixel of every pattern is black
    a_last_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel |-> (o_red == '0) && (o_green == '0) && (o_blue == '0))
        else $error("last pixel of tile not black");

    // alpha is fixed on every word
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_alpha == ptpr_pkg::ALPHA)
        else $error("alpha not 0xBF");

    // reset leaves the output invalid and busy low
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("block not idle after reset");

endmodule

bind palette_tile_pixel_renderer ptpr_checker u_ptpr_checker (.*);
